// File: design/vfme_pkg.sv
// Shared constants and types for the voxel face mesh emitter.
package vfme_pkg;

    localparam int MAX_DIM_DEF = 4096;

    // Widths of the configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSPARENT = 3'd0,
        CFG_LEVELS      = 3'd1,
        CFG_WIDTH       = 3'd2,
        CFG_HEIGHT      = 3'd3,
        CFG_SMOOTH      = 3'd4
    } t_cfg_idx;

    // Step lookup: 256 / levels for levels 1..STEP_TBL_N.
    localparam int STEP_FULL  = 256;
    localparam int STEP_TBL_N = 128;

    localparam int MAX_TRI = 12;

    // Face mask bit positions.
    localparam int F_LEFT  = 0;
    localparam int F_RIGHT = 1;
    localparam int F_TOP   = 2;
    localparam int F_BOT   = 3;
    localparam int F_FRONT = 4;
    localparam int F_BACK  = 5;

    // Corner masks for the slanted marching-squares cases (low four face bits).
    localparam logic [3:0] M_TL = 4'b0101;
    localparam logic [3:0] M_TR = 4'b0110;
    localparam logic [3:0] M_BL = 4'b1001;
    localparam logic [3:0] M_BR = 4'b1010;

    // Triangle: three 3-bit vertex codes, each dx*4 + dy*2 + dz, first in the top bits.
    typedef logic [8:0] t_tri;

    localparam t_tri PAIR_LEFT0  = 9'o012;
    localparam t_tri PAIR_LEFT1  = 9'o213;
    localparam t_tri PAIR_RIGHT0 = 9'o465;
    localparam t_tri PAIR_RIGHT1 = 9'o675;
    localparam t_tri PAIR_TOP0   = 9'o236;
    localparam t_tri PAIR_TOP1   = 9'o376;
    localparam t_tri PAIR_BOT0   = 9'o041;
    localparam t_tri PAIR_BOT1   = 9'o145;
    localparam t_tri PAIR_FRONT0 = 9'o024;
    localparam t_tri PAIR_FRONT1 = 9'o264;
    localparam t_tri PAIR_BACK0  = 9'o153;
    localparam t_tri PAIR_BACK1  = 9'o357;

    localparam t_tri DIAG_TL0 = 9'o016;
    localparam t_tri DIAG_TL1 = 9'o617;
    localparam t_tri DIAG_TL2 = 9'o064;
    localparam t_tri DIAG_TL3 = 9'o157;
    localparam t_tri DIAG_TR0 = 9'o425;
    localparam t_tri DIAG_TR1 = 9'o235;
    localparam t_tri DIAG_TR2 = 9'o402;
    localparam t_tri DIAG_TR3 = 9'o531;
    localparam t_tri DIAG_BL0 = 9'o245;
    localparam t_tri DIAG_BL1 = 9'o253;
    localparam t_tri DIAG_BL2 = 9'o426;
    localparam t_tri DIAG_BL3 = 9'o573;
    localparam t_tri DIAG_BR0 = 9'o061;
    localparam t_tri DIAG_BR1 = 9'o167;
    localparam t_tri DIAG_BR2 = 9'o026;
    localparam t_tri DIAG_BR3 = 9'o173;

endpackage

// File: design/voxel_face_mesh_emitter_unit.sv
// Top level of the voxel face mesh emitter: face culling and triangle emission.
//
// Input channel (i_valid / o_stall) takes one voxel cell per transaction: its
// column, row, level and the centre pixel with its four neighbours.
// Output channel (o_valid / i_stall) gives one triangle per transaction with
// three integer vertices, a last-triangle flag and the running solid count.
// A cell emits 0 to 12 triangles, one per output transaction; a cell
// that emits nothing drops out of the input register without using the list.
// Sustained rate is set by the output port: one triangle per cycle while
// i_stall is low, so a fully exposed cell holds the output longest and culled or empty cells less.
// The first triangle of a cell passes the input register and the triangle list
// register to the output register, straight through when nothing ahead of it is waiting.
// Stages: input register, triangle list register (cull, threshold multiply and
// list build in between), output register (vertex decode in between).
// When the receiver stalls, the output register holds its triangle; the list
// and input registers fill and then o_stall rises. o_stall follows i_stall in
// the same cycle once both inner stages are full, at a cell's last triangle.
// Reset clears all valid flags, the solid counter and the configuration registers
// (transparent 0, levels 1, width 1, height 1, smooth off). The user must write
// configuration through i_cfg_* only while idle; the block does not enforce it.
module voxel_face_mesh_emitter_unit #(
    parameter int MAX_DIM = vfme_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vfme_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vfme_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [11:0]                     i_col,
    input  logic [11:0]                     i_row,
    input  logic [7:0]                      i_level,
    input  logic [7:0]                      i_centre_pixel,
    input  logic [7:0]                      i_left_pixel,
    input  logic [7:0]                      i_right_pixel,
    input  logic [7:0]                      i_above_pixel,
    input  logic [7:0]                      i_below_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [12:0]                     o_ax,
    output logic signed [12:0]              o_ay,
    output logic [8:0]                      o_az,
    output logic [12:0]                     o_bx,
    output logic signed [12:0]              o_by,
    output logic [8:0]                      o_bz,
    output logic [12:0]                     o_cx,
    output logic signed [12:0]              o_cy,
    output logic [8:0]                      o_cz,
    output logic                            o_last_triangle,
    output logic [31:0]                     o_solid_cells
);
    import vfme_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > 13) ? DIM_W : 13;
    localparam int TRI_W = $clog2(MAX_TRI + 1);
    localparam int TBL_W = $clog2(STEP_TBL_N);

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  lvl;
        logic [7:0]  pc;
        logic [7:0]  pl;
        logic [7:0]  pr;
        logic [7:0]  pa;
        logic [7:0]  pb;
    } t_cell;

    // Configuration registers.
    logic [7:0]  r_transparent;
    logic [8:0]  r_levels;
    logic [8:0]  r_step;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic        r_smooth;

    // Step table, elaborated from constants.
    logic [8:0] step_tbl [STEP_TBL_N];
    for (genvar g = 0; g < STEP_TBL_N; g++) begin : g_step
        localparam int unsigned STEP_G = STEP_FULL / (g + 1);
        assign step_tbl[g] = 9'(STEP_G);
    end

    logic [8:0] cfg_lvl;
    logic [8:0] cfg_lvl_m1;
    logic [8:0] cfg_step;

    always_comb begin
        cfg_lvl    = (i_cfg_data[8:0] == 9'd0) ? 9'd1 : i_cfg_data[8:0];
        cfg_lvl_m1 = cfg_lvl - 9'd1;
        if (cfg_lvl <= 9'(STEP_TBL_N)) begin
            cfg_step = step_tbl[cfg_lvl_m1[TBL_W-1:0]];
        end else if (cfg_lvl <= 9'(STEP_FULL)) begin
            cfg_step = 9'd1;
        end else begin
            cfg_step = 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transparent <= 8'd0;
            r_levels      <= 9'd1;
            r_step        <= 9'(STEP_FULL);
            r_width       <= 13'd1;
            r_height      <= 13'd1;
            r_smooth      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRANSPARENT: r_transparent <= i_cfg_data[7:0];
                CFG_LEVELS: begin
                    r_levels <= cfg_lvl;
                    r_step   <= cfg_step;
                end
                CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                CFG_SMOOTH: r_smooth <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline registers.
    logic        r_a_valid;
    t_cell       r_a;
    logic        r_b_valid;
    t_tri        r_list [MAX_TRI];
    logic [TRI_W-1:0] r_cnt;
    logic [TRI_W-1:0] r_idx;
    logic [11:0] r_b_col;
    logic [11:0] r_b_row;
    logic [7:0]  r_b_lvl;
    logic [31:0] r_b_solid;
    logic [31:0] r_solid;
    logic        r_o_valid;

    // Culling and list build from the input register.
    logic [16:0]      thresh;
    logic [17:0]      thresh_up;
    logic [CMP_W-1:0] wid;
    logic [CMP_W-1:0] hei;
    logic [5:0]       faces;
    logic             diag_sel;
    t_tri             d0, d1, d2, d3;
    t_tri             lst [MAX_TRI];
    logic [TRI_W-1:0] n;
    logic [31:0]      n_solid;

    function automatic logic solid_at(input logic [7:0] p, input logic [7:0] tv,
                                      input logic [16:0] th);
        return (p != tv) && ({9'd0, p} >= th);
    endfunction

    always_comb begin
        thresh    = {9'd0, r_a.lvl} * {8'd0, r_step};
        thresh_up = {1'b0, thresh} + {9'd0, r_step};
        wid = CMP_W'(r_width);
        hei = CMP_W'(r_height);
        if (wid > CMP_W'(MAX_DIM)) wid = CMP_W'(MAX_DIM);
        if (hei > CMP_W'(MAX_DIM)) hei = CMP_W'(MAX_DIM);

        faces = 6'd0;
        if (solid_at(r_a.pc, r_transparent, thresh)) begin
            faces = 6'b111111;
            if (r_a.lvl != 8'd0) faces[F_FRONT] = 1'b0;
            if (({1'b0, r_a.lvl} + 9'd1 < r_levels) && ({10'd0, r_a.pc} >= thresh_up))
                faces[F_BACK] = 1'b0;
            if (r_a.col != 12'd0 && solid_at(r_a.pl, r_transparent, thresh))
                faces[F_LEFT] = 1'b0;
            if ((CMP_W'(r_a.col) + CMP_W'(1) < wid)
                    && solid_at(r_a.pr, r_transparent, thresh))
                faces[F_RIGHT] = 1'b0;
            if (r_a.row != 12'd0 && solid_at(r_a.pa, r_transparent, thresh))
                faces[F_TOP] = 1'b0;
            if ((CMP_W'(r_a.row) + CMP_W'(1) < hei)
                    && solid_at(r_a.pb, r_transparent, thresh))
                faces[F_BOT] = 1'b0;
        end

        diag_sel = 1'b0;
        d0 = DIAG_TL0;
        d1 = DIAG_TL1;
        d2 = DIAG_TL2;
        d3 = DIAG_TL3;
        if (r_smooth && r_levels == 9'd1) begin
            case (faces[3:0])
                M_TL: diag_sel = 1'b1;
                M_TR: begin
                    diag_sel = 1'b1;
                    d0 = DIAG_TR0; d1 = DIAG_TR1; d2 = DIAG_TR2; d3 = DIAG_TR3;
                end
                M_BL: begin
                    diag_sel = 1'b1;
                    d0 = DIAG_BL0; d1 = DIAG_BL1; d2 = DIAG_BL2; d3 = DIAG_BL3;
                end
                M_BR: begin
                    diag_sel = 1'b1;
                    d0 = DIAG_BR0; d1 = DIAG_BR1; d2 = DIAG_BR2; d3 = DIAG_BR3;
                end
                default: ;
            endcase
        end

        lst = '{default: '0};
        n   = '0;
        if (diag_sel) begin
            lst[0] = d0;
            lst[1] = d1;
            n = TRI_W'(2);
            if (faces[F_FRONT]) begin
                lst[n] = d2;
                n = n + TRI_W'(1);
            end
            if (faces[F_BACK]) begin
                lst[n] = d3;
                n = n + TRI_W'(1);
            end
        end else begin
            if (faces[F_BOT]) begin
                lst[n] = PAIR_BOT0; lst[n + TRI_W'(1)] = PAIR_BOT1; n = n + TRI_W'(2);
            end
            if (faces[F_TOP]) begin
                lst[n] = PAIR_TOP0; lst[n + TRI_W'(1)] = PAIR_TOP1; n = n + TRI_W'(2);
            end
            if (faces[F_LEFT]) begin
                lst[n] = PAIR_LEFT0; lst[n + TRI_W'(1)] = PAIR_LEFT1; n = n + TRI_W'(2);
            end
            if (faces[F_RIGHT]) begin
                lst[n] = PAIR_RIGHT0; lst[n + TRI_W'(1)] = PAIR_RIGHT1;
                n = n + TRI_W'(2);
            end
            if (faces[F_FRONT]) begin
                lst[n] = PAIR_FRONT0; lst[n + TRI_W'(1)] = PAIR_FRONT1;
                n = n + TRI_W'(2);
            end
            if (faces[F_BACK]) begin
                lst[n] = PAIR_BACK0; lst[n + TRI_W'(1)] = PAIR_BACK1;
                n = n + TRI_W'(2);
            end
        end

        // Saturate at all ones.
        n_solid = (r_solid == '1) ? r_solid : r_solid + 32'd1;
    end

    // Flow control.
    logic out_load;
    logic b_done;
    logic b_free;
    logic a_take;
    logic in_take;

    assign out_load = r_b_valid && (!r_o_valid || !i_stall);
    assign b_done   = out_load && (r_idx == r_cnt - TRI_W'(1));
    assign b_free   = !r_b_valid || b_done;
    // Empty cells drop straight out of the input register.
    assign a_take   = r_a_valid && ((n == '0) || b_free);
    assign o_stall  = r_a_valid && !a_take;
    assign in_take  = i_valid && !o_stall;

    // Vertex decode for the triangle being loaded into the output register.
    t_tri        cur;
    logic [12:0] vx [3];
    logic [12:0] vy [3];
    logic [8:0]  vz [3];

    always_comb begin
        cur = r_list[r_idx];
        for (int v = 0; v < 3; v++) begin
            vx[v] = {1'b0, r_b_col} + {12'd0, cur[8 - 3 * v]};
            vy[v] = {12'd0, cur[7 - 3 * v]} - {1'b0, r_b_row};
            vz[v] = {1'b0, r_b_lvl} + {8'd0, cur[6 - 3 * v]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_solid   <= 32'd0;
            r_idx     <= '0;
        end else begin
            if (in_take) begin
                r_a_valid <= 1'b1;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end

            if (a_take && n != '0) begin
                r_b_valid <= 1'b1;
                r_idx     <= '0;
                r_solid   <= n_solid;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end else if (out_load) begin
                r_idx <= r_idx + TRI_W'(1);
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a.col <= i_col;
            r_a.row <= i_row;
            r_a.lvl <= i_level;
            r_a.pc  <= i_centre_pixel;
            r_a.pl  <= i_left_pixel;
            r_a.pr  <= i_right_pixel;
            r_a.pa  <= i_above_pixel;
            r_a.pb  <= i_below_pixel;
        end
        if (a_take && n != '0) begin
            r_list    <= lst;
            r_cnt     <= n;
            r_b_col   <= r_a.col;
            r_b_row   <= r_a.row;
            r_b_lvl   <= r_a.lvl;
            r_b_solid <= n_solid;
        end
        if (out_load) begin
            o_ax            <= vx[0];
            o_ay            <= vy[0];
            o_az            <= vz[0];
            o_bx            <= vx[1];
            o_by            <= vy[1];
            o_bz            <= vz[1];
            o_cx            <= vx[2];
            o_cy            <= vy[2];
            o_cz            <= vz[2];
            o_last_triangle <= (r_idx == r_cnt - TRI_W'(1));
            o_solid_cells   <= r_b_solid;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// File: design/vfme_checker.sv
// Port-level assertions for the voxel face mesh emitter, bound to the top level.
module vfme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_last_triangle,
    input logic [12:0] o_ax,
    input logic [8:0]  o_az,
    input logic [31:0] o_solid_cells
);

    // Output channel is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled triangle holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ax) && $stable(o_az)
            && $stable(o_last_triangle))
        else $error("stalled transaction changed");

    // Triangles of one cell leave back to back.
    a_cell_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_triangle |=> o_valid)
        else $error("gap inside a cell's triangles");

    // The solid count is the same for every triangle of a cell.
    a_cell_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_triangle |=> $stable(o_solid_cells))
        else $error("solid count changed inside a cell");

endmodule

bind voxel_face_mesh_emitter_unit vfme_checker u_vfme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_last_triangle (o_last_triangle),
    .o_ax            (o_ax),
    .o_az            (o_az),
    .o_solid_cells   (o_solid_cells)
);
